### rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue core.
// No dependencies; used by dq_ctrl, dq_datapath and double_ended_queue_core.
`timescale 1ns / 1ps

package dq_pkg;

  // Operation codes carried by an item
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;

  // Word reported for front and back when nothing is held
  localparam logic [WordW-1:0] EmptyWord = {WordW{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // apply the operation to store, pointer and count
    logic rd;    // read front and back words from the store
  } ctrl_cmd_t;

endpackage

### rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
//   Channel   Handshake              Ports
//   command   start_i && !busy_o     cmd_i, value_i
//   result    done_o (one cycle)     front_value_o, back_value_o, is_empty_o,
//                                    entry_count_o, status_o
//
// Each item passes through four steps before the next is accepted: capture,
// update of the ring store, pointer and count, the registered two-port read of
// the front and back words, and presenting the result. busy_o rises once the
// item is captured and stays high until the result cycle ends.
// Reset empties the queue; store contents are not cleared, only held
// entries are ever reported. The result strobe cannot be stalled by the receiver.
`timescale 1ns / 1ps

module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] value_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic               is_empty_o,
  output logic [4:0]         entry_count_o,
  output logic [1:0]         status_o
);

  dq_pkg::ctrl_cmd_t ctrl_cmd;

  dq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (ctrl_cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .op_i          (cmd_i),
    .value_i       (value_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting an item");

  // A result is a single-cycle strobe followed by the idle state
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe longer than one cycle");

  // The strobe only appears while an item is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside an item");

  // Underflow leaves the queue empty
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == dq_pkg::STAT_UNDERFLOW)) |-> is_empty_o)
    else $error("underflow reported on a non-empty queue");
`endif

endmodule

### rtl/dq_ctrl.sv
// Sequencer for the double-ended queue: accept, execute, read, respond.
// Depends on dq_pkg for the command struct.
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output dq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Advance one step per cycle once an item is taken
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_READ;
      ST_READ: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive datapath commands and handshake
  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && start_i;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.rd   = (state_q == ST_READ);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

endmodule

### rtl/dq_datapath.sv
// Ring store, front pointer, entry count and result registers of the queue.
// Depends on dq_pkg for codes, widths and the command struct.
`timescale 1ns / 1ps

module dq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_pkg::ctrl_cmd_t         cmd_i,
  input  logic [1:0]                op_i,
  input  logic [dq_pkg::WordW-1:0]  value_i,
  output logic [dq_pkg::WordW-1:0]  front_value_o,
  output logic [dq_pkg::WordW-1:0]  back_value_o,
  output logic                      is_empty_o,
  output logic [dq_pkg::CountW-1:0] entry_count_o,
  output logic [1:0]                status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [dq_pkg::WordW-1:0] mem_q [DEPTH];

  dq_pkg::cmd_e             op_q;
  logic [dq_pkg::WordW-1:0] value_q;
  logic [AW-1:0]            front_q, front_d;
  logic [CW-1:0]            count_q, count_d;
  dq_pkg::status_e          status_q, status_d;
  logic [dq_pkg::WordW-1:0] rd_front_q, rd_back_q;

  logic          is_push, full, empty, wr_en;
  logic [AW-1:0] front_dec, front_inc, tail_addr, back_addr, wr_addr;
  logic [SW-1:0] tail_sum, back_sum, tail_wrap, back_wrap;
  logic [CW-1:0] back_off;
  logic [31:0]   count_ext;

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= dq_pkg::cmd_e'(op_i);
      value_q <= value_i;
    end
  end

  // Ring positions: neighbours of the front, the back slot and the slot past the back
  always_comb begin
    front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
    front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

    tail_sum  = SW'(front_q) + SW'(count_q);
    tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    tail_addr = tail_wrap[AW-1:0];

    back_off  = (count_q == '0) ? '0 : count_q - CW'(1);
    back_sum  = SW'(front_q) + SW'(back_off);
    back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    back_addr = back_wrap[AW-1:0];
  end

  // Decide the operation's effect
  always_comb begin
    is_push  = ~op_q[1];
    full     = (count_q == CW'(DEPTH));
    empty    = (count_q == '0);
    front_d  = front_q;
    count_d  = count_q;
    status_d = dq_pkg::STAT_OK;
    wr_en    = 1'b0;
    wr_addr  = tail_addr;
    case (op_q)
      dq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = dq_pkg::STAT_OVERFLOW;
        end else begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = front_dec;
        end
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_d = dq_pkg::STAT_OVERFLOW;
        end else begin
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_d = dq_pkg::STAT_UNDERFLOW;
        end else begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_d = dq_pkg::STAT_UNDERFLOW;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        status_d = dq_pkg::STAT_OK;
      end
    endcase
  end

  // Update pointer, count and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= dq_pkg::STAT_OK;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Store write on a push that fits
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en && is_push) begin
      mem_q[wr_addr] <= value_q;
    end
  end

  // Registered reads of the front and back words
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_front_q <= mem_q[front_q];
      rd_back_q  <= mem_q[back_addr];
    end
  end

  // Form the result
  assign count_ext     = 32'(count_q);
  assign is_empty_o    = empty;
  assign entry_count_o = count_ext[dq_pkg::CountW-1:0];
  assign front_value_o = empty ? dq_pkg::EmptyWord : rd_front_q;
  assign back_value_o  = empty ? dq_pkg::EmptyWord : rd_back_q;
  assign status_o      = status_q;

endmodule

### bench/tb.sv
// Self-checking bench for double_ended_queue_core: directed and random operations, each
// result checked field by field against a shadow ring store. Depends on dq_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth      = 16;
  localparam int unsigned RandItems  = 1550;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 12;

  typedef struct {
    dq_pkg::cmd_e cmd;
    logic [31:0]  value;
  } op_item_t;

  typedef struct {
    logic [31:0]     front;
    logic [31:0]     back;
    logic            empty;
    logic [4:0]      count;
    dq_pkg::status_e status;
  } outcome_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic [1:0]         cmd_i;
  logic signed [31:0] value_i;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] back_value_o;
  logic               is_empty_o;
  logic [4:0]         entry_count_o;
  logic [1:0]         status_o;

  op_item_t    pending_ops[$];
  outcome_t    expected_outcomes[$];
  logic        item_taken;
  int unsigned cycle_count;
  int unsigned error_count;

  // Shadow deque state
  logic [31:0] shadow_store [Depth];
  logic [3:0]  shadow_front;
  int unsigned shadow_held;

  double_ended_queue_core #(
    .DEPTH(Depth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  // Generate the clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one operation to the shadow deque and queue the outcome it must give
  task automatic deque_apply(input dq_pkg::cmd_e cmd, input logic [31:0] word);
    outcome_t    res;
    logic [3:0]  back_pos;
    res.status = dq_pkg::STAT_OK;
    case (cmd)
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
        if (shadow_held >= Depth) begin
          res.status = dq_pkg::STAT_OVERFLOW;
        end else if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
          shadow_front = shadow_front - 4'd1;
          shadow_store[shadow_front] = word;
          shadow_held++;
        end else begin
          shadow_store[4'(shadow_front + shadow_held)] = word;
          shadow_held++;
        end
      end
      default: begin
        if (shadow_held == 0) begin
          res.status = dq_pkg::STAT_UNDERFLOW;
        end else begin
          if (cmd == dq_pkg::CMD_POP_FRONT) shadow_front = shadow_front + 4'd1;
          shadow_held--;
        end
      end
    endcase
    if (shadow_held == 0) begin
      res.front = dq_pkg::EmptyWord;
      res.back  = dq_pkg::EmptyWord;
    end else begin
      back_pos  = 4'(shadow_front + shadow_held - 1);
      res.front = shadow_store[shadow_front];
      res.back  = shadow_store[back_pos];
    end
    res.empty = (shadow_held == 0);
    res.count = 5'(shadow_held);
    expected_outcomes = {expected_outcomes, res};
  endtask

  task automatic add_op(input dq_pkg::cmd_e cmd, input logic [31:0] word);
    op_item_t it;
    it.cmd   = cmd;
    it.value = word;
    pending_ops = {pending_ops, it};
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Sample at the rising edge: note accepted items, check results, count cycles
  always @(posedge clk_i) begin
    outcome_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start_i && !busy_o;
      if (start_i && !busy_o) deque_apply(dq_pkg::cmd_e'(cmd_i), value_i);
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = expected_outcomes[0];
          expected_outcomes.delete(0);
          if (front_value_o !== want.front)
            report_mismatch($sformatf("front got %h want %h", front_value_o, want.front));
          if (back_value_o !== want.back)
            report_mismatch($sformatf("back got %h want %h", back_value_o, want.back));
          if (is_empty_o !== want.empty)
            report_mismatch($sformatf("empty got %b want %b", is_empty_o, want.empty));
          if (entry_count_o !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", entry_count_o, want.count));
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        end
      end
    end
  end

  // Drive items at the falling edge, in bursts with random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    op_item_t it;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !item_taken) begin
      // hold the item until it is taken
    end else if (gap_left > 0) begin
      start_i <= 1'b0;
      gap_left--;
    end else if (pending_ops.size() > 0) begin
      it = pending_ops[0];
      pending_ops.delete(0);
      start_i <= 1'b1;
      cmd_i   <= it.cmd;
      value_i <= it.value;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  initial begin
    int unsigned  made;
    int unsigned  seg_len;
    int unsigned  push_pct;
    dq_pkg::cmd_e c;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    cmd_i        = dq_pkg::CMD_PUSH_FRONT;
    value_i      = '0;
    item_taken   = 1'b0;
    cycle_count  = 0;
    error_count  = 0;
    shadow_front = '0;
    shadow_held  = 0;

    // Directed: underflow both ends, extremes, last-entry pops, fill and overflow
    add_op(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
    add_op(dq_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
    add_op(dq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    add_op(dq_pkg::CMD_POP_BACK, 32'h0000_0000);
    add_op(dq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    add_op(dq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    for (int i = 0; i < Depth; i++) begin
      case (i % 4)
        0: add_op(dq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        1: add_op(dq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
        2: add_op(dq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        default: add_op(dq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
      endcase
    end
    add_op(dq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    add_op(dq_pkg::CMD_PUSH_BACK, 32'h8765_4321);

    // Random: segments biased towards filling, draining or balanced traffic
    made = 0;
    while (made < RandItems) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < seg_len && made < RandItems; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          c = ($urandom_range(0, 1) == 0) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK;
        else
          c = ($urandom_range(0, 1) == 0) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK;
        add_op(c, pick_word());
        made++;
      end
    end

    // Release reset away from the rising edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all items to be taken and all results to arrive
    while ((pending_ops.size() != 0 || start_i || expected_outcomes.size() != 0)
           && cycle_count < CycleLimit)
      @(posedge clk_i);

    if (cycle_count >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      repeat (DrainWait) @(posedge clk_i);
      if (expected_outcomes.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
      if (error_count == 0) begin
        $display("tb OK");
      end else begin
        $display("tb NOT OK");
      end
      $finish;
    end
  end

endmodule

### files.f
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue_core.sv
bench/tb.sv
